>>> sv/spts_pkg.sv
// ----------------------------------------------------------------------------
// spts_pkg
// Shared types and constants for the point-to-segment snap block.
// ----------------------------------------------------------------------------
`default_nettype none

package spts_pkg;

   localparam int COORD_BITS_DEF = 24;
   localparam int THR_W          = 24;
   localparam int DIST_W         = 50;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(2560);

   localparam logic [1:0] MODE_PERP   = 2'd0;
   localparam logic [1:0] MODE_KEEP_X = 2'd1;
   localparam logic [1:0] MODE_KEEP_Y = 2'd2;

   typedef enum logic [2:0] {
      A_EX, A_EY, A_DX, A_DY, A_DOT, A_AX, A_AY, A_THR
   } a_sel_type;

   typedef enum logic [2:0] {
      B_DX, B_DY, B_AX, B_AY, B_THR
   } b_sel_type;

   typedef enum logic [1:0] {
      D_LEN, D_DX, D_DY
   } den_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_go;
      a_sel_type   a_sel;
      b_sel_type   b_sel;
      logic        t0_wr;
      logic        t1_wr;
      logic        t_acc;
      logic        div_go;
      den_sel_type den_sel;
      logic        px_wr;
      logic        py_wr;
      logic        pos_vert;
      logic        pos_kx;
      logic        pos_ky;
      logic        measure;
      logic        finish;
      logic        snap_ok;
   } dp_cmd_type;

   typedef struct packed {
      logic       mul_busy;
      logic       div_busy;
      logic       vert;
      logic       dy_zero;
      logic [1:0] mode;
      logic       near_ok;
      logic       out_free;
   } dp_status_type;

endpackage

`default_nettype wire

>>> sv/spts_ctrl.sv
// ----------------------------------------------------------------------------
// spts_ctrl
// Sequencer: steps the shared multiplier and divider through one item.
// ----------------------------------------------------------------------------
`default_nettype none

module spts_ctrl import spts_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type st,
   output dp_cmd_type         cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DECIDE,
      S_MUL_EXDX, S_MUL_EYDY, S_MUL_DXDX, S_MUL_DYDY,
      S_MUL_DOTDX, S_DIV_X, S_MUL_DOTDY, S_DIV_Y,
      S_MUL_KX, S_DIV_KX, S_MUL_KY, S_DIV_KY,
      S_MEASURE, S_CHECK, S_MUL_AX, S_MUL_AY, S_MUL_THR,
      S_FINISH_SNAP, S_FINISH_NONE
   } state_type;

   state_type state_ff, state_in;
   logic      phase_ff, phase_in;
   logic      run_mul, run_div, mul_fin, div_fin;

   assign req_ready = (state_ff == S_IDLE);
   assign mul_fin   = phase_ff && !st.mul_busy;
   assign div_fin   = phase_ff && !st.div_busy;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      phase_in = phase_ff;
      run_mul  = 1'b0;
      run_div  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (st.vert) begin
               if (st.mode == MODE_KEEP_X) begin
                  state_in = S_FINISH_NONE;
               end else begin
                  cmd.pos_vert = 1'b1;
                  state_in     = S_MEASURE;
               end
            end else if (st.mode == MODE_KEEP_X) begin
               state_in = S_MUL_KX;
            end else if (st.mode == MODE_KEEP_Y) begin
               state_in = st.dy_zero ? S_FINISH_NONE : S_MUL_KY;
            end else begin
               state_in = S_MUL_EXDX;
            end
         end
         S_MUL_EXDX: begin
            cmd.a_sel = A_EX; cmd.b_sel = B_DX; run_mul = 1'b1;
            if (mul_fin) begin
               cmd.t0_wr = 1'b1; state_in = S_MUL_EYDY;
            end
         end
         S_MUL_EYDY: begin
            cmd.a_sel = A_EY; cmd.b_sel = B_DY; run_mul = 1'b1;
            if (mul_fin) begin
               cmd.t0_wr = 1'b1; cmd.t_acc = 1'b1; state_in = S_MUL_DXDX;
            end
         end
         S_MUL_DXDX: begin
            cmd.a_sel = A_DX; cmd.b_sel = B_DX; run_mul = 1'b1;
            if (mul_fin) begin
               cmd.t1_wr = 1'b1; state_in = S_MUL_DYDY;
            end
         end
         S_MUL_DYDY: begin
            cmd.a_sel = A_DY; cmd.b_sel = B_DY; run_mul = 1'b1;
            if (mul_fin) begin
               cmd.t1_wr = 1'b1; cmd.t_acc = 1'b1; state_in = S_MUL_DOTDX;
            end
         end
         S_MUL_DOTDX: begin
            cmd.a_sel = A_DOT; cmd.b_sel = B_DX; run_mul = 1'b1;
            if (mul_fin) state_in = S_DIV_X;
         end
         S_DIV_X: begin
            cmd.den_sel = D_LEN; run_div = 1'b1;
            if (div_fin) begin
               cmd.px_wr = 1'b1; state_in = S_MUL_DOTDY;
            end
         end
         S_MUL_DOTDY: begin
            cmd.a_sel = A_DOT; cmd.b_sel = B_DY; run_mul = 1'b1;
            if (mul_fin) state_in = S_DIV_Y;
         end
         S_DIV_Y: begin
            cmd.den_sel = D_LEN; run_div = 1'b1;
            if (div_fin) begin
               cmd.py_wr = 1'b1; state_in = S_MEASURE;
            end
         end
         S_MUL_KX: begin
            cmd.a_sel = A_EX; cmd.b_sel = B_DY; run_mul = 1'b1;
            if (mul_fin) state_in = S_DIV_KX;
         end
         S_DIV_KX: begin
            cmd.den_sel = D_DX; run_div = 1'b1;
            if (div_fin) begin
               cmd.py_wr = 1'b1; cmd.pos_kx = 1'b1; state_in = S_MEASURE;
            end
         end
         S_MUL_KY: begin
            cmd.a_sel = A_EY; cmd.b_sel = B_DX; run_mul = 1'b1;
            if (mul_fin) state_in = S_DIV_KY;
         end
         S_DIV_KY: begin
            cmd.den_sel = D_DY; run_div = 1'b1;
            if (div_fin) begin
               cmd.px_wr = 1'b1; cmd.pos_ky = 1'b1; state_in = S_MEASURE;
            end
         end
         S_MEASURE: begin
            cmd.measure = 1'b1;
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            state_in = st.near_ok ? S_MUL_AX : S_FINISH_NONE;
         end
         S_MUL_AX: begin
            cmd.a_sel = A_AX; cmd.b_sel = B_AX; run_mul = 1'b1;
            if (mul_fin) begin
               cmd.t0_wr = 1'b1; state_in = S_MUL_AY;
            end
         end
         S_MUL_AY: begin
            cmd.a_sel = A_AY; cmd.b_sel = B_AY; run_mul = 1'b1;
            if (mul_fin) begin
               cmd.t0_wr = 1'b1; cmd.t_acc = 1'b1; state_in = S_MUL_THR;
            end
         end
         S_MUL_THR: begin
            cmd.a_sel = A_THR; cmd.b_sel = B_THR; run_mul = 1'b1;
            if (mul_fin) begin
               cmd.t1_wr = 1'b1; state_in = S_FINISH_SNAP;
            end
         end
         S_FINISH_SNAP: begin
            if (st.out_free) begin
               cmd.finish = 1'b1; cmd.snap_ok = 1'b1; state_in = S_IDLE;
            end
         end
         S_FINISH_NONE: begin
            if (st.out_free) begin
               cmd.finish = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // Launch on the first cycle of an arithmetic step, finish when the unit drops busy.
      if (run_mul) begin
         cmd.mul_go = !phase_ff;
         phase_in   = !mul_fin;
      end
      if (run_div) begin
         cmd.div_go = !phase_ff;
         phase_in   = !div_fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/spts_dp.sv
// ----------------------------------------------------------------------------
// spts_dp
// Datapath: operand registers, shift-add multiplier, restoring divider,
// bounding box test, running best and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spts_dp import spts_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire dp_cmd_type                   cmd,
   output dp_status_type                     st,
   input  wire logic signed [COORD_BITS-1:0] req_point_x,
   input  wire logic signed [COORD_BITS-1:0] req_point_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_x1,
   input  wire logic signed [COORD_BITS-1:0] req_seg_y1,
   input  wire logic signed [COORD_BITS-1:0] req_seg_x2,
   input  wire logic signed [COORD_BITS-1:0] req_seg_y2,
   input  wire logic [1:0]                   req_mode,
   input  wire logic                         req_start_new,
   input  wire logic                         csr_wr_en,
   input  wire logic [THR_W-1:0]             csr_wr_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_improved,
   output logic                              rsp_found_any,
   output logic signed [COORD_BITS-1:0]      rsp_best_x,
   output logic signed [COORD_BITS-1:0]      rsp_best_y
);

   localparam int W   = COORD_BITS;
   localparam int XW  = W + 1;
   localparam int MB  = (XW > THR_W) ? XW : THR_W;
   localparam int NA  = 2 * W + 3;
   localparam int NP  = NA + MB;
   localparam int TW  = NP + 1;
   localparam int DW  = 2 * W + 3;
   localparam int NN  = NP + 2;
   localparam int RW  = DW + 2;
   localparam int QM  = W + 3;
   localparam int QW  = W + 4;
   localparam int PW  = W + 5;
   localparam int EW  = (PW + 1 > THR_W) ? PW + 1 : THR_W + 1;
   localparam int MCW = $clog2(MB + 1);
   localparam int DCW = $clog2(NN + 1);
   localparam logic [NN-1:0] LIMIT = NN'(1) << (W + 2);

   // Item registers
   logic signed [W-1:0] mx_ff, my_ff, x1_ff, y1_ff, x2_ff, y2_ff;
   logic [1:0]          mode_ff;
   logic [THR_W-1:0]    thr_ff;

   logic signed [XW-1:0] dx, dy, ex, ey;
   assign dx = XW'(x2_ff) - XW'(x1_ff);
   assign dy = XW'(y2_ff) - XW'(y1_ff);
   assign ex = XW'(mx_ff) - XW'(x1_ff);
   assign ey = XW'(my_ff) - XW'(y1_ff);

   // Shift-add multiplier, one multiplier bit per cycle
   logic signed [NA:0]   a_val, a_neg;
   logic signed [MB:0]   b_val, b_neg;
   logic [NA-1:0]        a_mag, ma_ff, ma_in;
   logic [MB-1:0]        b_mag, mb_ff, mb_in;
   logic [NP-1:0]        acc_ff, acc_in;
   logic                 msign_ff, msign_in, mbusy_ff, mbusy_in;
   logic [MCW-1:0]       mcnt_ff, mcnt_in;
   logic signed [TW-1:0] prod_pos, prod, t0_ff, t0_in, t1_ff, t1_in;
   logic [THR_W-1:0]     ax_ff, ax_in, ay_ff, ay_in;

   always_comb begin
      case (cmd.a_sel)
         A_EX:    a_val = (NA+1)'(ex);
         A_EY:    a_val = (NA+1)'(ey);
         A_DX:    a_val = (NA+1)'(dx);
         A_DY:    a_val = (NA+1)'(dy);
         A_DOT:   a_val = $signed(t0_ff[NA:0]);
         A_AX:    a_val = (NA+1)'(ax_ff);
         A_AY:    a_val = (NA+1)'(ay_ff);
         default: a_val = (NA+1)'(thr_ff);
      endcase
      case (cmd.b_sel)
         B_DX:    b_val = (MB+1)'(dx);
         B_DY:    b_val = (MB+1)'(dy);
         B_AX:    b_val = (MB+1)'(ax_ff);
         B_AY:    b_val = (MB+1)'(ay_ff);
         default: b_val = (MB+1)'(thr_ff);
      endcase
      a_neg = -a_val;
      b_neg = -b_val;
      a_mag = a_val[NA] ? a_neg[NA-1:0] : a_val[NA-1:0];
      b_mag = b_val[MB] ? b_neg[MB-1:0] : b_val[MB-1:0];
   end

   always_comb begin
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      acc_in   = acc_ff;
      msign_in = msign_ff;
      mcnt_in  = mcnt_ff;
      mbusy_in = mbusy_ff;
      if (cmd.mul_go) begin
         ma_in    = a_mag;
         mb_in    = b_mag;
         acc_in   = '0;
         msign_in = a_val[NA] ^ b_val[MB];
         mcnt_in  = MCW'(MB);
         mbusy_in = 1'b1;
      end else if (mbusy_ff) begin
         acc_in   = {acc_ff[NP-2:0], 1'b0} + (mb_ff[MB-1] ? {{MB{1'b0}}, ma_ff} : '0);
         mb_in    = {mb_ff[MB-2:0], 1'b0};
         mcnt_in  = mcnt_ff - MCW'(1);
         mbusy_in = (mcnt_ff != MCW'(1));
      end
   end

   assign prod_pos = $signed({1'b0, acc_ff});
   assign prod     = msign_ff ? -prod_pos : prod_pos;
   assign t0_in    = cmd.t0_wr ? (cmd.t_acc ? t0_ff + prod : prod) : t0_ff;
   assign t1_in    = cmd.t1_wr ? (cmd.t_acc ? t1_ff + prod : prod) : t1_ff;

   // Restoring divider, round to nearest via (2n + d) / 2d
   logic signed [DW:0]   den_val, den_neg;
   logic [DW-1:0]        den_mag;
   logic [NN-1:0]        num_ff, num_in;
   logic [DW:0]          den2_ff, den2_in;
   logic [RW-1:0]        rem_ff, rem_in, rem_sh;
   logic                 ge, qneg_ff, qneg_in, dbusy_ff, dbusy_in;
   logic [DCW-1:0]       dcnt_ff, dcnt_in;
   logic [QM-1:0]        q_mag;
   logic signed [QW-1:0] q_pos, qs;

   always_comb begin
      case (cmd.den_sel)
         D_LEN:   den_val = $signed(t1_ff[DW:0]);
         D_DX:    den_val = (DW+1)'(dx);
         default: den_val = (DW+1)'(dy);
      endcase
      den_neg = -den_val;
      den_mag = den_val[DW] ? den_neg[DW-1:0] : den_val[DW-1:0];
      rem_sh  = {rem_ff[RW-2:0], num_ff[NN-1]};
      ge      = (rem_sh >= {1'b0, den2_ff});
   end

   always_comb begin
      num_in   = num_ff;
      den2_in  = den2_ff;
      rem_in   = rem_ff;
      qneg_in  = qneg_ff;
      dcnt_in  = dcnt_ff;
      dbusy_in = dbusy_ff;
      if (cmd.div_go) begin
         num_in   = {1'b0, acc_ff, 1'b0} + NN'(den_mag);
         den2_in  = {den_mag, 1'b0};
         rem_in   = '0;
         qneg_in  = msign_ff ^ den_val[DW];
         dcnt_in  = DCW'(NN);
         dbusy_in = 1'b1;
      end else if (dbusy_ff) begin
         rem_in   = ge ? rem_sh - {1'b0, den2_ff} : rem_sh;
         num_in   = {num_ff[NN-2:0], ge};
         dcnt_in  = dcnt_ff - DCW'(1);
         dbusy_in = (dcnt_ff != DCW'(1));
      end
   end

   assign q_mag = (num_ff > LIMIT) ? LIMIT[QM-1:0] : num_ff[QM-1:0];
   assign q_pos = $signed({1'b0, q_mag});
   assign qs    = qneg_ff ? -q_pos : q_pos;

   // Snapped point, box test and distance
   logic signed [PW-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [W-1:0]  lox, hix, loy, hiy;
   logic signed [EW-1:0] dxm, dym;
   logic [EW-1:0]        axa, aya;
   logic                 inbox, ok_ff, ok_in;

   always_comb begin
      px_in = px_ff;
      py_in = py_ff;
      if (cmd.pos_vert) begin
         px_in = PW'(x1_ff);
         py_in = PW'(my_ff);
      end
      if (cmd.px_wr)  px_in = PW'(x1_ff) + PW'(qs);
      if (cmd.py_wr)  py_in = PW'(y1_ff) + PW'(qs);
      if (cmd.pos_kx) px_in = PW'(mx_ff);
      if (cmd.pos_ky) py_in = PW'(my_ff);
   end

   always_comb begin
      lox   = (x1_ff < x2_ff) ? x1_ff : x2_ff;
      hix   = (x1_ff < x2_ff) ? x2_ff : x1_ff;
      loy   = (y1_ff < y2_ff) ? y1_ff : y2_ff;
      hiy   = (y1_ff < y2_ff) ? y2_ff : y1_ff;
      inbox = (px_ff >= PW'(lox)) && (px_ff <= PW'(hix)) &&
              (py_ff >= PW'(loy)) && (py_ff <= PW'(hiy));
      dxm   = EW'(px_ff) - EW'(mx_ff);
      dym   = EW'(py_ff) - EW'(my_ff);
      axa   = dxm[EW-1] ? EW'(-dxm) : EW'(dxm);
      aya   = dym[EW-1] ? EW'(-dym) : EW'(dym);
      ok_in = ok_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      if (cmd.measure) begin
         ok_in = inbox && (axa[EW-1:THR_W] == '0) && (aya[EW-1:THR_W] == '0);
         ax_in = axa[THR_W-1:0];
         ay_in = aya[THR_W-1:0];
      end
   end

   // Running best and result register
   logic [DIST_W-1:0]   best_ff, best_in;
   logic                have_ff, have_in, improved;
   logic signed [W-1:0] bx_ff, bx_in, by_ff, by_in;
   logic                rv_ff, rv_in, rimp_ff, rimp_in, rfound_ff, rfound_in;
   logic signed [W-1:0] rx_ff, rx_in, ry_ff, ry_in;

   assign improved = cmd.snap_ok && ok_ff &&
                     (t0_ff[TW-2:0] < t1_ff[TW-2:0]) &&
                     (t0_ff[TW-2:0] < (TW-1)'(best_ff));

   always_comb begin
      best_in   = best_ff;
      have_in   = have_ff;
      bx_in     = bx_ff;
      by_in     = by_ff;
      rv_in     = rv_ff;
      rimp_in   = rimp_ff;
      rfound_in = rfound_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      if (cmd.load && req_start_new) begin
         best_in = '1;
         have_in = 1'b0;
         bx_in   = '0;
         by_in   = '0;
      end
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      if (cmd.finish) begin
         if (improved) begin
            best_in = t0_ff[DIST_W-1:0];
            have_in = 1'b1;
            bx_in   = px_ff[W-1:0];
            by_in   = py_ff[W-1:0];
         end
         rv_in     = 1'b1;
         rimp_in   = improved;
         rfound_in = have_ff || improved;
         rx_in     = improved ? px_ff[W-1:0] : bx_ff;
         ry_in     = improved ? py_ff[W-1:0] : by_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THR_RESET;
         mbusy_ff <= 1'b0;
         dbusy_ff <= 1'b0;
         best_ff  <= '1;
         have_ff  <= 1'b0;
         bx_ff    <= '0;
         by_ff    <= '0;
         rv_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) thr_ff <= csr_wr_data;
         mbusy_ff <= mbusy_in;
         dbusy_ff <= dbusy_in;
         best_ff  <= best_in;
         have_ff  <= have_in;
         bx_ff    <= bx_in;
         by_ff    <= by_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mx_ff   <= req_point_x;
         my_ff   <= req_point_y;
         x1_ff   <= req_seg_x1;
         y1_ff   <= req_seg_y1;
         x2_ff   <= req_seg_x2;
         y2_ff   <= req_seg_y2;
         mode_ff <= req_mode;
      end
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      acc_ff    <= acc_in;
      msign_ff  <= msign_in;
      mcnt_ff   <= mcnt_in;
      t0_ff     <= t0_in;
      t1_ff     <= t1_in;
      num_ff    <= num_in;
      den2_ff   <= den2_in;
      rem_ff    <= rem_in;
      qneg_ff   <= qneg_in;
      dcnt_ff   <= dcnt_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      ok_ff     <= ok_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      rimp_ff   <= rimp_in;
      rfound_ff <= rfound_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
   end

   assign st.mul_busy = mbusy_ff;
   assign st.div_busy = dbusy_ff;
   assign st.vert     = (dx == '0);
   assign st.dy_zero  = (dy == '0);
   assign st.mode     = mode_ff;
   assign st.near_ok  = ok_ff;
   assign st.out_free = !rv_ff || rsp_ready;

   assign rsp_valid     = rv_ff;
   assign rsp_improved  = rimp_ff;
   assign rsp_found_any = rfound_ff;
   assign rsp_best_x    = rx_ff;
   assign rsp_best_y    = ry_ff;

endmodule

`default_nettype wire

>>> sv/snap_point_to_segment_top.sv
// ----------------------------------------------------------------------------
// snap_point_to_segment_top
// Snaps a cursor point onto one segment per item and keeps the closest snap.
// ----------------------------------------------------------------------------
//  channel   ports       direction   moves
//  request   req_*       in          one cursor point, segment, mode, start flag
//  response  rsp_*       out         improved flag, found flag, best point
//  control   csr_*       in          snap threshold write, no handshake
//
//  One item at a time. A perpendicular snap runs nine multiplies and two
//  divides, a keep-x or keep-y snap four multiplies and one divide, a vertical
//  segment three multiplies; keep-x on a vertical or keep-y on a horizontal
//  segment finishes with no snap and no arithmetic. A foot outside the box or
//  too far skips the last three multiplies. Reset returns the threshold to 2560.
//  A stalled response holds; the next item is taken, its finish waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module snap_point_to_segment_top import spts_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_point_x,
   input  wire logic signed [COORD_BITS-1:0] req_point_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_x1,
   input  wire logic signed [COORD_BITS-1:0] req_seg_y1,
   input  wire logic signed [COORD_BITS-1:0] req_seg_x2,
   input  wire logic signed [COORD_BITS-1:0] req_seg_y2,
   input  wire logic [1:0]                   req_mode,
   input  wire logic                         req_start_new,
   input  wire logic                         csr_wr_en,
   input  wire logic [THR_W-1:0]             csr_wr_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_improved,
   output logic                              rsp_found_any,
   output logic signed [COORD_BITS-1:0]      rsp_best_x,
   output logic signed [COORD_BITS-1:0]      rsp_best_y
);

   dp_cmd_type    cmd;
   dp_status_type st;

   // Sequencer: drive one multiply or divide step at a time
   spts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // Arithmetic, box test, running best and response register
   spts_dp #(.COORD_BITS(COORD_BITS)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_seg_x1    (req_seg_x1),
      .req_seg_y1    (req_seg_y1),
      .req_seg_x2    (req_seg_x2),
      .req_seg_y2    (req_seg_y2),
      .req_mode      (req_mode),
      .req_start_new (req_start_new),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_improved  (rsp_improved),
      .rsp_found_any (rsp_found_any),
      .rsp_best_x    (rsp_best_x),
      .rsp_best_y    (rsp_best_y)
   );

endmodule

`default_nettype wire

>>> sv/spts_checker.sv
// ----------------------------------------------------------------------------
// spts_checker
// Port-level checks for the snap block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spts_checker import spts_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic                         rsp_improved,
   input wire logic                         rsp_found_any,
   input wire logic signed [COORD_BITS-1:0] rsp_best_x,
   input wire logic signed [COORD_BITS-1:0] rsp_best_y
);

   // A pending response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // One item in flight: the block goes busy after taking an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("took a second item while busy");

   // A new best implies a snap exists
   a_improved_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_improved |-> rsp_found_any)
      else $error("improved without found");

   // With no snap the best point reads as zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found_any |-> (rsp_best_x == '0) && (rsp_best_y == '0))
      else $error("best point nonzero without a snap");

endmodule

bind snap_point_to_segment_top spts_checker #(.COORD_BITS(COORD_BITS)) u_spts_checker (.*);

`default_nettype wire
